// ----- sv/mi2_pkg.sv -----
// ----------------------------------------------------------------------------
// mi2_pkg
// Shared constants and types of the 2x2 matrix inverse.
// ----------------------------------------------------------------------------
package mi2_pkg;

   localparam int ELEM_WIDTH_DEF = 24;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int LANES          = 4;

   // register map, index = byte address / 4
   localparam logic REG_DET_EPSILON = 1'b0;
   localparam logic [31:0] DET_EPSILON_RESET = 32'd512;

   // per-word control that travels along the divider chain
   typedef struct packed {
      logic             singular;
      logic [LANES-1:0] neg;       // sign of each result element
   } flags_type;

endpackage

// ----- sv/matrix2x2_inverse.sv -----
// ----------------------------------------------------------------------------
// matrix2x2_inverse
// Inverse of a 2x2 signed fixed-point matrix, one matrix per word.
// ----------------------------------------------------------------------------
// Takes one matrix every cycle unless the output stalls, and returns its
// inverse through four front stages (input, products, difference,
// magnitude and singular test), one restoring-division cell per quotient
// bit, each cell doing all four elements at once, and the output register.
// The division cell chain sets the latency; every stage passes a word on
// each cycle, and a stalled output lets the stages behind it fill up
// before the input stalls.
// The determinant is exact; |det| <= det_epsilon (register at byte address
// 0, units of 2^-(2*FRAC_BITS)) gives zeros with singular set. Otherwise
// each element is adjugate/det truncated toward zero and clipped to the
// element range, with saturated set on any clip.
module matrix2x2_inverse #(
   parameter int ELEM_WIDTH = mi2_pkg::ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = mi2_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // a00, a01, a10, a11, ELEM_WIDTH bits each, from the lowest bit up
   input  logic [((4*ELEM_WIDTH+7)/8)*8-1:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // r00, r01, r10, r11, ELEM_WIDTH bits each, from the lowest bit up
   output logic [((4*ELEM_WIDTH+7)/8)*8-1:0] rsp_tdata,
   // singular, saturated, from the lowest bit up
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import mi2_pkg::*;

   localparam int W  = ELEM_WIDTH;
   localparam int RW = 2 * W;
   localparam int NW = W + 2 * FRAC_BITS;
   localparam int NC = NW;

   logic [31:0] eps_ff;

   // configuration register
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == REG_DET_EPSILON) ? eps_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= DET_EPSILON_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   csr_paddr[2] == REG_DET_EPSILON) begin
         eps_ff <= csr_pwdata;
      end
   end

   logic [W-1:0] a_w [LANES];

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         a_w[k] = req_tdata[k*W +: W];
      end
   end

   // chain links: index 0 is the front, index NC the last cell
   logic             vld_w [NC+1];
   logic             rdy_w [NC+1];
   logic [RW-1:0]    den_w [NC+1];
   logic [NW-1:0]    num_w [NC+1][LANES];
   logic [RW-1:0]    rem_w [NC+1][LANES];
   logic [W-1:0]     quo_w [NC+1][LANES];
   logic [LANES-1:0] big_w [NC+1];
   flags_type        flags_w [NC+1];

   mi2_front #(
      .ELEM_WIDTH (ELEM_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .epsilon  (eps_ff),
      .up_valid (req_tvalid),
      .up_ready (req_tready),
      .a_i      (a_w),
      .dn_valid (vld_w[0]),
      .dn_ready (rdy_w[0]),
      .den_o    (den_w[0]),
      .num_o    (num_w[0]),
      .flags_o  (flags_w[0])
   );

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         rem_w[0][k] = '0;
         quo_w[0][k] = '0;
      end
      big_w[0] = '0;
   end

   for (genvar c = 0; c < NC; c++) begin : g_cell
      mi2_div_cell #(
         .ELEM_WIDTH (ELEM_WIDTH),
         .FRAC_BITS  (FRAC_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .up_valid (vld_w[c]),
         .up_ready (rdy_w[c]),
         .den_i    (den_w[c]),
         .num_i    (num_w[c]),
         .rem_i    (rem_w[c]),
         .quo_i    (quo_w[c]),
         .big_i    (big_w[c]),
         .flags_i  (flags_w[c]),
         .dn_valid (vld_w[c+1]),
         .dn_ready (rdy_w[c+1]),
         .den_o    (den_w[c+1]),
         .num_o    (num_w[c+1]),
         .rem_o    (rem_w[c+1]),
         .quo_o    (quo_w[c+1]),
         .big_o    (big_w[c+1]),
         .flags_o  (flags_w[c+1])
      );
   end

   logic [W-1:0] res_w [LANES];
   logic         singular_w, saturated_w;

   mi2_out #(
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_out (
      .clock       (clock),
      .reset       (reset),
      .up_valid    (vld_w[NC]),
      .up_ready    (rdy_w[NC]),
      .quo_i       (quo_w[NC]),
      .big_i       (big_w[NC]),
      .flags_i     (flags_w[NC]),
      .dn_valid    (rsp_tvalid),
      .dn_ready    (rsp_tready),
      .res_o       (res_w),
      .singular_o  (singular_w),
      .saturated_o (saturated_w)
   );

   always_comb begin
      rsp_tdata = '0;
      for (int k = 0; k < LANES; k++) begin
         rsp_tdata[k*W +: W] = res_w[k];
      end
   end

   assign rsp_tuser = {saturated_w, singular_w};

endmodule

// ----- sv/mi2_front.sv -----
// ----------------------------------------------------------------------------
// mi2_front
// Input register, determinant products, difference, magnitude and singular
// test; prepares the four adjugate numerators for the divider chain.
// ----------------------------------------------------------------------------
module mi2_front #(
   parameter int ELEM_WIDTH = mi2_pkg::ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = mi2_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [31:0]                          epsilon,
   input  logic                                 up_valid,
   output logic                                 up_ready,
   input  logic [ELEM_WIDTH-1:0]                a_i [mi2_pkg::LANES],
   output logic                                 dn_valid,
   input  logic                                 dn_ready,
   output logic [2*ELEM_WIDTH-1:0]              den_o,
   output logic [ELEM_WIDTH+2*FRAC_BITS-1:0]    num_o [mi2_pkg::LANES],
   output mi2_pkg::flags_type                   flags_o
);
   import mi2_pkg::*;

   localparam int W  = ELEM_WIDTH;
   localparam int PW = 2 * W;
   localparam int DW = PW + 1;
   localparam int NW = W + 2 * FRAC_BITS;
   localparam int CW = (DW > 34) ? DW : 34;

   logic          va_ff, vb_ff, vc_ff, vd_ff;
   logic          rdy_a, rdy_b, rdy_c, rdy_d;
   logic [W-1:0]  a_ff  [LANES];
   logic [W-1:0]  ab_ff [LANES];
   logic [W-1:0]  ac_ff [LANES];
   logic signed [PW-1:0] p_ff, q_ff, p_in, q_in;
   logic [DW-1:0] diff_ff, diff_in, dabs;
   logic signed [CW-1:0] diff_x, eps_x;
   logic [PW-1:0] den_ff;
   logic [NW-1:0] num_ff [LANES];
   logic [NW-1:0] num_in [LANES];
   flags_type     flags_ff, flags_in;

   // each stage moves when it is empty or its successor takes its word
   assign rdy_d    = !vd_ff || dn_ready;
   assign rdy_c    = !vc_ff || rdy_d;
   assign rdy_b    = !vb_ff || rdy_c;
   assign rdy_a    = !va_ff || rdy_b;
   assign up_ready = rdy_a;

   assign p_in    = $signed(a_ff[0]) * $signed(a_ff[3]);
   assign q_in    = $signed(a_ff[2]) * $signed(a_ff[1]);
   assign diff_in = {p_ff[PW-1], p_ff} - {q_ff[PW-1], q_ff};

   assign dabs   = diff_ff[DW-1] ? (~diff_ff + 1'b1) : diff_ff;
   assign diff_x = $signed({{(CW-DW){diff_ff[DW-1]}}, diff_ff});
   assign eps_x  = $signed({{(CW-32){1'b0}}, epsilon});

   always_comb begin
      logic [W-1:0] src;
      logic [W-1:0] mag;
      logic         aneg;
      flags_in.singular = (diff_x <= eps_x) && (diff_x >= -eps_x);
      for (int k = 0; k < LANES; k++) begin
         // adjugate: a11, -a01, -a10, a00
         src  = (k == 0) ? ac_ff[3] : (k == 3) ? ac_ff[0] : ac_ff[k];
         mag  = src[W-1] ? (~src + 1'b1) : src;
         if (k == 1 || k == 2) begin
            aneg = !src[W-1] && (|src);
         end else begin
            aneg = src[W-1];
         end
         flags_in.neg[k] = aneg ^ diff_ff[DW-1];
         num_in[k]       = NW'(mag) << (2 * FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
         vd_ff <= 1'b0;
      end else begin
         if (rdy_a) va_ff <= up_valid;
         if (rdy_b) vb_ff <= va_ff;
         if (rdy_c) vc_ff <= vb_ff;
         if (rdy_d) vd_ff <= vc_ff;
      end
      if (rdy_a && up_valid) a_ff <= a_i;
      if (rdy_b && va_ff) begin
         p_ff  <= p_in;
         q_ff  <= q_in;
         ab_ff <= a_ff;
      end
      if (rdy_c && vb_ff) begin
         diff_ff <= diff_in;
         ac_ff   <= ab_ff;
      end
      if (rdy_d && vc_ff) begin
         den_ff   <= dabs[PW-1:0];
         num_ff   <= num_in;
         flags_ff <= flags_in;
      end
   end

   assign dn_valid = vd_ff;
   assign den_o    = den_ff;
   assign num_o    = num_ff;
   assign flags_o  = flags_ff;

endmodule

// ----- sv/mi2_div_cell.sv -----
// ----------------------------------------------------------------------------
// mi2_div_cell
// One restoring-division step for all four elements: takes the next
// numerator bit, trial-subtracts the determinant, shifts in one quotient bit.
// ----------------------------------------------------------------------------
module mi2_div_cell #(
   parameter int ELEM_WIDTH = mi2_pkg::ELEM_WIDTH_DEF,
   parameter int FRAC_BITS  = mi2_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              up_valid,
   output logic                              up_ready,
   input  logic [2*ELEM_WIDTH-1:0]           den_i,
   input  logic [ELEM_WIDTH+2*FRAC_BITS-1:0] num_i [mi2_pkg::LANES],
   input  logic [2*ELEM_WIDTH-1:0]           rem_i [mi2_pkg::LANES],
   input  logic [ELEM_WIDTH-1:0]             quo_i [mi2_pkg::LANES],
   input  logic [mi2_pkg::LANES-1:0]         big_i,
   input  mi2_pkg::flags_type                flags_i,
   output logic                              dn_valid,
   input  logic                              dn_ready,
   output logic [2*ELEM_WIDTH-1:0]           den_o,
   output logic [ELEM_WIDTH+2*FRAC_BITS-1:0] num_o [mi2_pkg::LANES],
   output logic [2*ELEM_WIDTH-1:0]           rem_o [mi2_pkg::LANES],
   output logic [ELEM_WIDTH-1:0]             quo_o [mi2_pkg::LANES],
   output logic [mi2_pkg::LANES-1:0]         big_o,
   output mi2_pkg::flags_type                flags_o
);
   import mi2_pkg::*;

   localparam int W  = ELEM_WIDTH;
   localparam int RW = 2 * W;
   localparam int NW = W + 2 * FRAC_BITS;

   logic            v_ff;
   logic            load;
   logic [RW-1:0]   den_ff;
   logic [NW-1:0]   num_ff [LANES];
   logic [NW-1:0]   num_in [LANES];
   logic [RW-1:0]   rem_ff [LANES];
   logic [RW-1:0]   rem_in [LANES];
   logic [W-1:0]    quo_ff [LANES];
   logic [W-1:0]    quo_in [LANES];
   logic [LANES-1:0] big_ff, big_in;
   flags_type       flags_ff;

   assign up_ready = !v_ff || dn_ready;
   assign load     = up_valid && up_ready;

   always_comb begin
      logic [RW:0] trial;
      logic        ge;
      for (int k = 0; k < LANES; k++) begin
         trial     = {rem_i[k], num_i[k][NW-1]};
         ge        = trial >= {1'b0, den_i};
         rem_in[k] = ge ? RW'(trial - {1'b0, den_i}) : trial[RW-1:0];
         num_in[k] = num_i[k] << 1;
         quo_in[k] = {quo_i[k][W-2:0], ge};
         // a bit shifted out of the top means the quotient is past any limit
         big_in[k] = big_i[k] | quo_i[k][W-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (up_ready) begin
         v_ff <= up_valid;
      end
      if (load) begin
         den_ff   <= den_i;
         num_ff   <= num_in;
         rem_ff   <= rem_in;
         quo_ff   <= quo_in;
         big_ff   <= big_in;
         flags_ff <= flags_i;
      end
   end

   assign dn_valid = v_ff;
   assign den_o    = den_ff;
   assign num_o    = num_ff;
   assign rem_o    = rem_ff;
   assign quo_o    = quo_ff;
   assign big_o    = big_ff;
   assign flags_o  = flags_ff;

endmodule

// ----- sv/mi2_out.sv -----
// ----------------------------------------------------------------------------
// mi2_out
// Saturation, sign and singular masking of the quotients; holds the result
// word in the output register until it is taken.
// ----------------------------------------------------------------------------
module mi2_out #(
   parameter int ELEM_WIDTH = mi2_pkg::ELEM_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      up_valid,
   output logic                      up_ready,
   input  logic [ELEM_WIDTH-1:0]     quo_i [mi2_pkg::LANES],
   input  logic [mi2_pkg::LANES-1:0] big_i,
   input  mi2_pkg::flags_type        flags_i,
   output logic                      dn_valid,
   input  logic                      dn_ready,
   output logic [ELEM_WIDTH-1:0]     res_o [mi2_pkg::LANES],
   output logic                      singular_o,
   output logic                      saturated_o
);
   import mi2_pkg::*;

   localparam int W = ELEM_WIDTH;
   localparam logic [W-1:0] POS_LIMIT = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] NEG_LIMIT = {1'b1, {(W-1){1'b0}}};

   logic         v_ff;
   logic [W-1:0] res_ff [LANES];
   logic [W-1:0] res_in [LANES];
   logic         singular_ff, saturated_ff, saturated_in;

   assign up_ready = !v_ff || dn_ready;

   always_comb begin
      logic [W-1:0] limit;
      logic [W-1:0] mag;
      logic         clip;
      saturated_in = 1'b0;
      for (int k = 0; k < LANES; k++) begin
         limit = flags_i.neg[k] ? NEG_LIMIT : POS_LIMIT;
         clip  = big_i[k] || (quo_i[k] > limit);
         mag   = clip ? limit : quo_i[k];
         if (flags_i.singular) begin
            res_in[k] = '0;
         end else begin
            res_in[k]    = flags_i.neg[k] ? (~mag + 1'b1) : mag;
            saturated_in = saturated_in | clip;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (up_ready) begin
         v_ff <= up_valid;
      end
      if (up_valid && up_ready) begin
         res_ff       <= res_in;
         singular_ff  <= flags_i.singular;
         saturated_ff <= saturated_in;
      end
   end

   assign dn_valid    = v_ff;
   assign res_o       = res_ff;
   assign singular_o  = singular_ff;
   assign saturated_o = saturated_ff;

endmodule
